>>> hw/rtl/hashed_key_frequency_counter_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the hashed key frequency counter
// Shared clock and reset are the module's clock and reset ports.
// ----------------------------------------------------------------------------
`ifndef HASHED_KEY_FREQUENCY_COUNTER_MACROS_SVH
`define HASHED_KEY_FREQUENCY_COUNTER_MACROS_SVH

`ifndef ASSERT_OFF
// condition holds whenever the trigger holds
`define HKFC_ASSERT_IMPL(label, trig, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |-> (cond)) \
      else $error(msg);
// condition holds at every clock edge out of reset
`define HKFC_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);
`else
`define HKFC_ASSERT_IMPL(label, trig, cond, msg)
`define HKFC_ASSERT_ALWAYS(label, cond, msg)
`endif

`endif

>>> hw/rtl/hkfc_pkg.sv
// ----------------------------------------------------------------------------
// hkfc_pkg
// Sizes, hash constants and action codes of the hashed key frequency counter.
// ----------------------------------------------------------------------------
package hkfc_pkg;

   localparam int BUCKETS   = 4093;
   localparam int ENTRIES   = 4096;
   localparam int KEY_BYTES = 8;

   localparam int KEY_W  = 8 * KEY_BYTES;
   localparam int LEN_W  = 4;
   localparam int ID_W   = 12;
   localparam int FREQ_W = 31;
   localparam int NF_W   = 13;
   localparam int ACT_W  = 3;
   localparam int HASH_W = 32;
   localparam int BKT_W  = $clog2(BUCKETS);

   localparam logic [HASH_W-1:0] HASH_START = 32'd1159241;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = 31'h7fffffff;

   localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd0;
   localparam logic [ACT_W-1:0] ACT_LOOKUP = 3'd1;
   localparam logic [ACT_W-1:0] ACT_READ   = 3'd2;
   localparam logic [ACT_W-1:0] ACT_WRITE  = 3'd3;
   localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

endpackage

>>> hw/rtl/hkfc_hash.sv
// ----------------------------------------------------------------------------
// hkfc_hash
// Byte-serial shift-xor-add key hash followed by an iterative fold that
// reduces the low 31 bits of the hash modulo the bucket count.
// ----------------------------------------------------------------------------
module hkfc_hash (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [hkfc_pkg::KEY_W-1:0]  key,
   input  logic [hkfc_pkg::LEN_W-1:0]  len,
   output logic                        done,
   output logic [hkfc_pkg::BKT_W-1:0]  bucket
);
   import hkfc_pkg::*;

   localparam logic [1:0] HP_IDLE = 2'd0;
   localparam logic [1:0] HP_MIX  = 2'd1;
   localparam logic [1:0] HP_FOLD = 2'd2;

   // 2^BKT_W is congruent to FOLD modulo BUCKETS
   localparam int FOLD = (2 ** BKT_W) - BUCKETS;

   logic [1:0]        phase_ff, phase_in;
   logic [HASH_W-1:0] h_ff, h_in;
   logic [LEN_W-1:0]  idx_ff, idx_in;
   logic [30:0]       v_ff, v_in;
   logic [7:0]        cur_byte;
   logic [30:0]       v_hi;
   logic [30:0]       v_fold;

   assign cur_byte = key[{idx_ff[2:0], 3'b000} +: 8];
   assign v_hi     = v_ff >> BKT_W;
   assign v_fold   = (v_hi * 31'(FOLD)) + {{(31-BKT_W){1'b0}}, v_ff[BKT_W-1:0]};
   assign bucket   = v_ff[BKT_W-1:0];

   always_comb begin
      phase_in = phase_ff;
      h_in     = h_ff;
      idx_in   = idx_ff;
      v_in     = v_ff;
      done     = 1'b0;
      case (phase_ff)
         HP_IDLE: begin
            if (start) begin
               h_in     = HASH_START;
               idx_in   = '0;
               phase_in = HP_MIX;
            end
         end
         HP_MIX: begin
            if (idx_ff < len) begin
               h_in   = h_ff ^ ((h_ff << 5) + (h_ff >> 2) + {24'b0, cur_byte});
               idx_in = idx_ff + 1'b1;
            end else begin
               v_in     = h_ff[30:0];
               phase_in = HP_FOLD;
            end
         end
         HP_FOLD: begin
            if (v_ff < 31'(BUCKETS)) begin
               done     = 1'b1;
               phase_in = HP_IDLE;
            end else if (v_ff < 31'(2 * BUCKETS)) begin
               v_in = v_ff - 31'(BUCKETS);
            end else begin
               v_in = v_fold;
            end
         end
         default: begin
            phase_in = HP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= HP_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      h_ff   <= h_in;
      idx_ff <= idx_in;
      v_ff   <= v_in;
   end

endmodule

>>> hw/rtl/hashed_key_frequency_counter.sv
// ----------------------------------------------------------------------------
// hashed_key_frequency_counter
// Counts key occurrences in a chained hash table held in block memories.
// ----------------------------------------------------------------------------
// One item is in flight at a time. A count or lookup runs the byte-serial
// hash over the key length, the fold for the bucket modulo, the bucket head
// read, a registered memory read and a compare for every entry visited on
// the chain, a link step for a new entry, and a load of the result register.
// Read and write by id read the entry when the id is valid, then load the
// result register. After reset and after a clear, the bucket head memory is
// swept to zero at one entry a cycle while no item is taken; configuration
// writes are taken throughout. The result register lets the next item start
// while a result still waits.
module hashed_key_frequency_counter (
   input  logic         clock,
   input  logic         reset,
   // key[63:0], key_length[67:64], entry_id[79:68], new_frequency[110:80]
   input  logic [111:0] req_tdata,
   // action[2:0]
   input  logic [2:0]   req_tuser,
   input  logic         req_tvalid,
   output logic         req_tready,
   // result_id[11:0], frequency[42:12], stored_key[106:43],
   // stored_length[110:107], next_free_id[123:111]
   output logic [127:0] rsp_tdata,
   // overflow[0]
   output logic         rsp_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [0:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import hkfc_pkg::*;

`include "hashed_key_frequency_counter_macros.svh"

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_HASH = 4'd1;
   localparam logic [3:0] ST_BRD  = 4'd2;
   localparam logic [3:0] ST_BCHK = 4'd3;
   localparam logic [3:0] ST_ERD  = 4'd4;
   localparam logic [3:0] ST_ECHK = 4'd5;
   localparam logic [3:0] ST_LINK = 4'd6;
   localparam logic [3:0] ST_RESP = 4'd7;
   localparam logic [3:0] ST_CLR  = 4'd8;

   localparam int KL_W = KEY_W + LEN_W;

   function automatic logic id_ok(input logic [ID_W-1:0] id, input logic [NF_W-1:0] nf);
      return (id != '0) && ({1'b0, id} < nf);
   endfunction

   // memories
   logic [ID_W-1:0]   bkt_mem [BUCKETS];
   logic [KL_W-1:0]   kl_mem  [ENTRIES];
   logic [FREQ_W-1:0] cnt_mem [ENTRIES];
   logic [ID_W-1:0]   lnk_mem [ENTRIES];

   logic [ID_W-1:0]   bkt_rd_ff;
   logic [KL_W-1:0]   kl_rd_ff;
   logic [FREQ_W-1:0] cnt_rd_ff;
   logic [ID_W-1:0]   lnk_rd_ff;

   logic              bkt_we;
   logic [BKT_W-1:0]  bkt_wa;
   logic [ID_W-1:0]   bkt_wd;
   logic              kl_we;
   logic              cnt_we;
   logic [ID_W-1:0]   cnt_wa;
   logic [FREQ_W-1:0] cnt_wd;
   logic              lnk_we;
   logic [ID_W-1:0]   lnk_wa;
   logic [ID_W-1:0]   lnk_wd;

   // control and item registers
   logic [3:0]        state_ff, state_in;
   logic [ACT_W-1:0]  act_ff, act_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [LEN_W-1:0]  len_ff, len_in;
   logic [FREQ_W-1:0] nfreq_ff, nfreq_in;
   logic              mode_ff, mode_in;
   logic [NF_W-1:0]   nf_ff, nf_in;
   logic [ID_W-1:0]   pos_ff, pos_in;
   logic [ID_W-1:0]   tail_ff, tail_in;
   logic [BKT_W-1:0]  bkt_ff, bkt_in;
   logic [BKT_W-1:0]  clr_ff, clr_in;
   logic              clr_resp_ff, clr_resp_in;

   logic [ID_W-1:0]   res_id_ff, res_id_in;
   logic [FREQ_W-1:0] res_freq_ff, res_freq_in;
   logic [KEY_W-1:0]  res_key_ff, res_key_in;
   logic [LEN_W-1:0]  res_len_ff, res_len_in;
   logic              res_ovf_ff, res_ovf_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [127:0]      rsp_data_ff, rsp_data_in;
   logic              rsp_ovf_ff, rsp_ovf_in;

   logic              hash_start;
   logic              hash_done;
   logic [BKT_W-1:0]  hash_bucket;

   logic [LEN_W-1:0]  req_len;
   logic [KEY_W-1:0]  req_key;
   logic              req_xfer;
   logic              do_miss;
   logic              key_hit;
   logic [FREQ_W-1:0] cnt_inc;

   hkfc_hash u_hash (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (key_ff),
      .len    (len_ff),
      .done   (hash_done),
      .bucket (hash_bucket)
   );

   // clamp the length and drop bytes beyond it
   always_comb begin
      req_len = (req_tdata[67:64] > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                        : req_tdata[67:64];
      for (int i = 0; i < KEY_BYTES; i++) begin
         req_key[i*8 +: 8] = (LEN_W'(i) < req_len) ? req_tdata[i*8 +: 8] : 8'h00;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign key_hit    = (act_ff == ACT_READ) || (act_ff == ACT_WRITE) || !mode_ff ||
                       (kl_rd_ff == {len_ff, key_ff});
   assign cnt_inc    = (cnt_rd_ff < FREQ_MAX) ? cnt_rd_ff + 1'b1 : cnt_rd_ff;

   always_comb begin
      state_in    = state_ff;
      act_in      = act_ff;
      key_in      = key_ff;
      len_in      = len_ff;
      nfreq_in    = nfreq_ff;
      nf_in       = nf_ff;
      pos_in      = pos_ff;
      tail_in     = tail_ff;
      bkt_in      = bkt_ff;
      clr_in      = clr_ff;
      clr_resp_in = clr_resp_ff;
      res_id_in   = res_id_ff;
      res_freq_in = res_freq_ff;
      res_key_in  = res_key_ff;
      res_len_in  = res_len_ff;
      res_ovf_in  = res_ovf_ff;
      hash_start  = 1'b0;
      do_miss     = 1'b0;
      bkt_we      = 1'b0;
      bkt_wa      = bkt_ff;
      bkt_wd      = pos_ff;
      kl_we       = 1'b0;
      cnt_we      = 1'b0;
      cnt_wa      = pos_ff;
      cnt_wd      = cnt_inc;
      lnk_we      = 1'b0;
      lnk_wa      = pos_ff;
      lnk_wd      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               act_in      = req_tuser;
               key_in      = req_key;
               len_in      = req_len;
               nfreq_in    = req_tdata[110:80];
               res_id_in   = '0;
               res_freq_in = '0;
               res_key_in  = '0;
               res_len_in  = '0;
               res_ovf_in  = 1'b0;
               case (req_tuser)
                  ACT_COUNT, ACT_LOOKUP: begin
                     hash_start = 1'b1;
                     state_in   = ST_HASH;
                  end
                  ACT_READ, ACT_WRITE: begin
                     pos_in   = req_tdata[79:68];
                     state_in = id_ok(req_tdata[79:68], nf_ff) ? ST_ERD : ST_RESP;
                  end
                  ACT_CLEAR: begin
                     nf_in       = NF_W'(1);
                     clr_in      = '0;
                     clr_resp_in = 1'b1;
                     state_in    = ST_CLR;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               bkt_in   = hash_bucket;
               state_in = ST_BRD;
            end
         end
         ST_BRD: begin
            state_in = ST_BCHK;
         end
         ST_BCHK: begin
            tail_in = '0;
            if (id_ok(bkt_rd_ff, nf_ff)) begin
               pos_in   = bkt_rd_ff;
               state_in = ST_ERD;
            end else begin
               do_miss = 1'b1;
            end
         end
         ST_ERD: begin
            state_in = ST_ECHK;
         end
         ST_ECHK: begin
            if (key_hit) begin
               res_id_in  = pos_ff;
               res_key_in = kl_rd_ff[KEY_W-1:0];
               res_len_in = kl_rd_ff[KL_W-1:KEY_W];
               case (act_ff)
                  ACT_COUNT: begin
                     cnt_we      = 1'b1;
                     res_freq_in = cnt_inc;
                  end
                  ACT_WRITE: begin
                     cnt_we      = 1'b1;
                     cnt_wd      = nfreq_ff;
                     res_freq_in = nfreq_ff;
                  end
                  default: begin
                     res_freq_in = cnt_rd_ff;
                  end
               endcase
               state_in = ST_RESP;
            end else begin
               tail_in = pos_ff;
               if (id_ok(lnk_rd_ff, nf_ff)) begin
                  pos_in   = lnk_rd_ff;
                  state_in = ST_ERD;
               end else begin
                  do_miss = 1'b1;
               end
            end
         end
         ST_LINK: begin
            // hook the new entry onto the chain tail or the bucket head
            if (tail_ff != '0) begin
               lnk_we = 1'b1;
               lnk_wa = tail_ff;
               lnk_wd = pos_ff;
            end else begin
               bkt_we = 1'b1;
            end
            nf_in       = nf_ff + 1'b1;
            res_id_in   = pos_ff;
            res_freq_in = FREQ_W'(1);
            res_key_in  = key_ff;
            res_len_in  = len_ff;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         ST_CLR: begin
            bkt_we = 1'b1;
            bkt_wa = clr_ff;
            bkt_wd = '0;
            if (clr_ff == BKT_W'(BUCKETS - 1)) begin
               state_in    = clr_resp_ff ? ST_RESP : ST_IDLE;
               clr_resp_in = 1'b0;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // key not on the chain: lookup gives zeros, count allocates an entry or flags overflow when full
      if (do_miss) begin
         state_in = ST_RESP;
         if (act_ff == ACT_COUNT) begin
            if (nf_ff >= NF_W'(ENTRIES)) begin
               res_ovf_in = 1'b1;
            end else begin
               pos_in   = nf_ff[ID_W-1:0];
               kl_we    = 1'b1;
               cnt_we   = 1'b1;
               cnt_wa   = nf_ff[ID_W-1:0];
               cnt_wd   = FREQ_W'(1);
               lnk_we   = 1'b1;
               lnk_wa   = nf_ff[ID_W-1:0];
               lnk_wd   = '0;
               state_in = ST_LINK;
            end
         end
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if ((state_ff == ST_RESP) && (!rsp_valid_ff || rsp_tready)) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0, nf_ff, res_len_ff, res_key_ff, res_freq_ff, res_id_ff};
         rsp_ovf_in   = res_ovf_ff;
      end
   end

   assign mode_in = (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                     (csr_paddr == 1'b0)) ? csr_pwdata[0] : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         nf_ff        <= NF_W'(1);
         mode_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         clr_resp_ff  <= clr_resp_in;
         nf_ff        <= nf_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      act_ff      <= act_in;
      key_ff      <= key_in;
      len_ff      <= len_in;
      nfreq_ff    <= nfreq_in;
      pos_ff      <= pos_in;
      tail_ff     <= tail_in;
      bkt_ff      <= bkt_in;
      res_id_ff   <= res_id_in;
      res_freq_ff <= res_freq_in;
      res_key_ff  <= res_key_in;
      res_len_ff  <= res_len_in;
      res_ovf_ff  <= res_ovf_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ovf_ff  <= rsp_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (bkt_we) begin
         bkt_mem[bkt_wa] <= bkt_wd;
      end
      bkt_rd_ff <= bkt_mem[bkt_ff];
   end

   always_ff @(posedge clock) begin
      if (kl_we) begin
         kl_mem[nf_ff[ID_W-1:0]] <= {len_ff, key_ff};
      end
      kl_rd_ff <= kl_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      cnt_rd_ff <= cnt_mem[pos_ff];
   end

   always_ff @(posedge clock) begin
      if (lnk_we) begin
         lnk_mem[lnk_wa] <= lnk_wd;
      end
      lnk_rd_ff <= lnk_mem[pos_ff];
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign csr_prdata = {31'b0, mode_ff};
   assign csr_pready = 1'b1;

   `HKFC_ASSERT_ALWAYS(a_nf_range, (nf_ff != '0) && (nf_ff <= NF_W'(ENTRIES)), "next free id out of range")
   `HKFC_ASSERT_IMPL(a_ovf_no_id, rsp_valid_ff && rsp_ovf_ff, rsp_data_ff[ID_W-1:0] == '0, "overflow result carries an id")
   `HKFC_ASSERT_IMPL(a_clr_blocks, state_ff == ST_CLR, !req_tready, "item taken during bucket sweep")
   `HKFC_ASSERT_IMPL(a_link_valid, state_ff == ST_LINK, (pos_ff != '0) && ({1'b0, pos_ff} == nf_ff), "linked entry is not the next free id")

endmodule
